/* src/ray_cast_range_sensor_unit_assert.svh */
// Assertion macros for the ray cast range sensor unit.
// Included by the top level; depends on nothing else.
`ifndef RAY_CAST_RANGE_SENSOR_UNIT_ASSERT_SVH
`define RAY_CAST_RANGE_SENSOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RCRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RCRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define RCRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* src/rcrs_pkg.sv */
// Shared types and constants of the ray cast range sensor unit.
// Used by rcrs_sin, rcrs_div and the top level; depends on nothing.
package rcrs_pkg;

  // Field and datapath widths
  localparam int RANGE_W    = 10;  // max_range register
  localparam int STEPS_W    = 10;
  localparam int FRAC_W     = 17;  // Q0.16 range fraction, 65536 included
  localparam int DIV_W      = 27;  // steps * 65536 + max_range / 2
  localparam int PHASE_W    = 16;  // 65536 = one turn
  localparam int SIN_W      = 16;  // signed Q1.14
  localparam int MAG_W      = 15;  // magnitude of Q1.14, up to 16384
  localparam int POS_W      = 26;  // signed beam coordinate, Q.14
  localparam int FRAC_SHIFT = 14;
  localparam int CELL_W     = 13;  // cell index wide enough to compare with 4096
  localparam int HEAD_W     = 12;
  localparam int S_DATA_W   = 72;
  localparam int M_DATA_W   = 48;

  localparam logic [RANGE_W-1:0] RANGE_RESET = 10'd100;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  // Beam indexes
  typedef logic [2:0] beam_t;
  localparam beam_t BEAM_FRONT   = 3'd0;
  localparam beam_t BEAM_LEFT    = 3'd1;
  localparam beam_t BEAM_RIGHT   = 3'd2;
  localparam beam_t BEAM_LEFT45  = 3'd3;
  localparam beam_t BEAM_RIGHT45 = 3'd4;

  // Phase and polynomial constants
  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 16'd16384;
  localparam logic [PHASE_W-1:0] PHASE_EIGHTH  = 16'd8192;
  localparam logic [MAG_W-1:0]   SIN_C1        = 15'd1160;
  localparam logic [MAG_W-1:0]   SIN_C2        = 15'd10512;
  localparam logic [MAG_W-1:0]   SIN_C3        = 15'd25736;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_GO,
    ST_SIN_WAIT,
    ST_COS_GO,
    ST_COS_WAIT,
    ST_STEP,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } scan_state_t;

  typedef enum logic [2:0] {
    SIN_IDLE,
    SIN_Z2,
    SIN_T1,
    SIN_T2,
    SIN_T3,
    SIN_DONE
  } sin_state_t;

  // Heading offset of a beam's direction pair
  function automatic logic [PHASE_W-1:0] beam_phase_offset(beam_t b);
    logic [PHASE_W-1:0] off;
    case (b)
      BEAM_LEFT45:  off = PHASE_EIGHTH;
      BEAM_RIGHT45: off = -PHASE_EIGHTH;
      default:      off = '0;
    endcase
    return off;
  endfunction

endpackage

/* src/ray_cast_range_sensor_unit.sv */
// Top level of the ray cast range sensor unit: sequencer, beam stepper, map.
// Depends on rcrs_pkg, rcrs_ram, rcrs_sin, rcrs_div and the assertion header.
//
// Usage:
//   s_* channel takes items. s_tuser is the kind: a write item stores one
//   map bit and finishes in the cycle it is accepted (one write per cycle while idle);
//   a scan item casts five beams and yields five result items on m_*,
//   beam index in m_tuser, m_tlast set on the fifth.
//   cfg_we/cfg_wdata write max_range; write it only while the unit is idle.
//   Each beam of a scan runs two sine passes on the shared multiplier, then
//   a map check per step (the step state, then the check state) with k + 1
//   checks, where k is the step count of that beam, then starts, runs and
//   ends the divider and ends in its emit step; the map read per step sets
//   the bulk of a scan.
//   s_tready is low for the whole scan.
//   A finished result waits in the output register; the next beam is
//   computed meanwhile and holds in its emit step while the receiver stalls.
//   After the fifth result is loaded, s_tready rises even if it is not yet
//   taken. Reset clears the sequencer, the output valid and sets max_range
//   to 100; the map is not cleared and must be written before it is read.

`include "ray_cast_range_sensor_unit_assert.svh"

module ray_cast_range_sensor_unit #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512,
  parameter int ANGLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // max_range register write
  input  logic                            cfg_we,
  input  logic [rcrs_pkg::RANGE_W-1:0]    cfg_wdata,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cell_x[8:0], cell_y[17:9], occupied[18], pos_x[35:19], pos_y[52:36],
  // heading[64:53], zero pad[71:65]
  input  logic [rcrs_pkg::S_DATA_W-1:0]   s_tdata,
  // kind[0]
  input  logic                            s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit_x[8:0], hit_y[17:9], steps[27:18], range_fraction[44:28],
  // collided[45], zero pad[47:46]
  output logic [rcrs_pkg::M_DATA_W-1:0]   m_tdata,
  // beam[2:0]
  output logic [2:0]                      m_tuser,
  output logic                            m_tlast
);
  import rcrs_pkg::*;

  localparam int DEPTH       = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW          = $clog2(DEPTH);
  localparam int LIN_W       = 2 * CELL_W;
  localparam int PHASE_SHIFT = PHASE_W - ANGLE_BITS;
  localparam logic [PHASE_W-1:0] ANGLE_MASK = PHASE_W'((32'd1 << ANGLE_BITS) - 32'd1);

  // Input fields
  logic [8:0]        in_cell_x;
  logic [8:0]        in_cell_y;
  logic              in_occupied;
  logic [16:0]       in_pos_x;
  logic [16:0]       in_pos_y;
  logic [HEAD_W-1:0] in_heading;

  assign in_cell_x   = s_tdata[8:0];
  assign in_cell_y   = s_tdata[17:9];
  assign in_occupied = s_tdata[18];
  assign in_pos_x    = s_tdata[35:19];
  assign in_pos_y    = s_tdata[52:36];
  assign in_heading  = s_tdata[64:53];

  scan_state_t state, state_next;

  logic [RANGE_W-1:0]      max_range;
  beam_t                   beam;
  logic [PHASE_W-1:0]      phase;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;
  logic signed [SIN_W-1:0] sin_s;
  logic signed [SIN_W-1:0] dir_x;
  logic signed [SIN_W-1:0] dir_y;
  logic signed [POS_W-1:0] bx;
  logic signed [POS_W-1:0] by;
  logic [STEPS_W-1:0]      k;
  logic                    off_q;
  logic                    collided;

  // Output register
  logic [8:0]        out_hit_x;
  logic [8:0]        out_hit_y;
  logic [STEPS_W-1:0] out_steps;
  logic [FRAC_W-1:0] out_frac;
  logic              out_collided;
  beam_t             out_beam;
  logic              out_last;

  // Control
  logic               accept;
  logic               sin_start;
  logic [PHASE_W-1:0] sin_phase;
  logic               sin_done;
  logic signed [SIN_W-1:0] sin_value;
  logic               div_start;
  logic               div_done;
  logic [FRAC_W-1:0]  div_quot;
  logic               out_free;
  logic               out_load;
  logic               wall;
  logic               stop;

  // Beam cell of the current position
  logic [CELL_W-1:0] cur_cx;
  logic [CELL_W-1:0] cur_cy;
  logic              x_neg;
  logic              y_neg;
  logic              x_high;
  logic              y_high;
  logic              off_map;
  logic [LIN_W-1:0]  rd_lin;
  logic [LIN_W-1:0]  wr_lin;
  logic              wr_in_map;
  logic              ram_we;
  logic              ram_rdata;
  logic [8:0]        hit_x;
  logic [8:0]        hit_y;
  logic [PHASE_W-1:0] head_phase;

  assign cur_cx  = CELL_W'(bx[POS_W-2:FRAC_SHIFT]);
  assign cur_cy  = CELL_W'(by[POS_W-2:FRAC_SHIFT]);
  assign x_neg   = bx[POS_W-1];
  assign y_neg   = by[POS_W-1];
  assign x_high  = cur_cx >= CELL_W'(MAP_WIDTH);
  assign y_high  = cur_cy >= CELL_W'(MAP_HEIGHT);
  assign off_map = x_neg | y_neg | x_high | y_high;
  assign rd_lin  = LIN_W'(cur_cy) * LIN_W'(MAP_WIDTH) + LIN_W'(cur_cx);

  // Clamp the stop cell into the map, then keep 9 bits
  assign hit_x = x_neg ? 9'd0 : (x_high ? 9'(MAP_WIDTH - 1) : cur_cx[8:0]);
  assign hit_y = y_neg ? 9'd0 : (y_high ? 9'(MAP_HEIGHT - 1) : cur_cy[8:0]);

  // Map writes land straight from the input channel; drop writes off the map
  assign wr_lin    = LIN_W'(in_cell_y) * LIN_W'(MAP_WIDTH) + LIN_W'(in_cell_x);
  assign wr_in_map = (CELL_W'(in_cell_x) < CELL_W'(MAP_WIDTH)) &&
                     (CELL_W'(in_cell_y) < CELL_W'(MAP_HEIGHT));

  assign head_phase = PHASE_W'(({{(PHASE_W-HEAD_W){1'b0}}, in_heading} & ANGLE_MASK)
                               << PHASE_SHIFT);

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign wall     = off_q | ram_rdata;
  assign stop     = wall || (k >= max_range);

  rcrs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_lin[AW-1:0]),
    .wdata (in_occupied),
    .raddr (rd_lin[AW-1:0]),
    .rdata (ram_rdata)
  );

  rcrs_sin u_sin (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .phase (sin_phase),
    .done  (sin_done),
    .value (sin_value)
  );

  rcrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (k),
    .divisor  (max_range),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid && s_tuser == KIND_SCAN) state_next = ST_SIN_GO;
      ST_SIN_GO:   state_next = ST_SIN_WAIT;
      ST_SIN_WAIT: if (sin_done) state_next = ST_COS_GO;
      ST_COS_GO:   state_next = ST_COS_WAIT;
      ST_COS_WAIT: if (sin_done) state_next = ST_STEP;
      ST_STEP:     state_next = ST_CHECK;
      ST_CHECK:    state_next = stop ? ST_DIV_GO : ST_STEP;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (beam == BEAM_RIGHT45) ? ST_IDLE : ST_SIN_GO;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    sin_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    sin_phase = phase + beam_phase_offset(beam);
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid && s_tuser == KIND_WRITE && wr_in_map;
      end
      ST_SIN_GO: sin_start = 1'b1;
      ST_COS_GO: begin
        // cosine is the sine a quarter turn on
        sin_start = 1'b1;
        sin_phase = phase + beam_phase_offset(beam) + PHASE_QUARTER;
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_EMIT:   out_load  = out_free;
      default:   s_tready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_range <= RANGE_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_range <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Beam datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser == KIND_SCAN) begin
          beam    <= BEAM_FRONT;
          phase   <= head_phase;
          // Q9.8 to Q.14
          start_x <= {3'b000, in_pos_x, 6'b000000};
          start_y <= {3'b000, in_pos_y, 6'b000000};
        end
      end
      ST_SIN_WAIT: begin
        if (sin_done) begin
          sin_s <= sin_value;
        end
      end
      ST_COS_WAIT: begin
        if (sin_done) begin
          // sin_s is sine, sin_value cosine of the beam's base phase
          case (beam)
            BEAM_FRONT: begin
              dir_x <= sin_value;
              dir_y <= sin_s;
            end
            BEAM_LEFT, BEAM_LEFT45: begin
              dir_x <= sin_s;
              dir_y <= -sin_value;
            end
            default: begin
              dir_x <= -sin_s;
              dir_y <= sin_value;
            end
          endcase
          bx <= start_x;
          by <= start_y;
          k  <= '0;
        end
      end
      ST_STEP: off_q <= off_map;
      ST_CHECK: begin
        // the first cell of the front beam is the sensor's own cell
        if (beam == BEAM_FRONT && k == '0) begin
          collided <= wall;
        end
        if (!stop) begin
          k  <= k + 1'b1;
          bx <= bx + POS_W'(dir_x);
          by <= by + POS_W'(dir_y);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_hit_x    <= hit_x;
          out_hit_y    <= hit_y;
          out_steps    <= k;
          out_frac     <= div_quot;
          out_collided <= collided;
          out_beam     <= beam;
          out_last     <= (beam == BEAM_RIGHT45);
          beam         <= beam + 1'b1;
        end
      end
      default: off_q <= off_q;
    endcase
  end

  assign m_tdata = {2'b00, out_collided, out_frac, out_steps, out_hit_y, out_hit_x};
  assign m_tuser = out_beam;
  assign m_tlast = out_last;

  `RCRS_ASSERT_IMPLY(a_last_on_final_beam, clk, rst, m_tvalid, m_tlast == (m_tuser == BEAM_RIGHT45), "tlast does not match the final beam")
  `RCRS_ASSERT_IMPLY(a_beam_in_range, clk, rst, m_tvalid, m_tuser <= BEAM_RIGHT45, "beam index out of range")
  `RCRS_ASSERT_NEXT(a_scan_starts_front, clk, rst, accept && s_tuser == KIND_SCAN, state == ST_SIN_GO && beam == BEAM_FRONT, "scan did not start at the front beam")
  `RCRS_ASSERT_NEXT(a_step_advances, clk, rst, state == ST_CHECK && !stop, state == ST_STEP && k == $past(k) + 1'b1, "beam step did not advance")

endmodule

/* src/rcrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the occupancy map; depends on nothing.
module rcrs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rcrs_sin.sv */
// Iterative Q1.14 sine unit: one shared 15x15 multiplier, four passes.
// Depends on rcrs_pkg.
module rcrs_sin (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rcrs_pkg::PHASE_W-1:0]        phase,
  output logic                                done,
  output logic signed [rcrs_pkg::SIN_W-1:0]   value
);
  import rcrs_pkg::*;

  sin_state_t state, state_next;

  logic [MAG_W-1:0]   z;
  logic [MAG_W-1:0]   z2;
  logic [MAG_W-1:0]   acc;
  logic               neg;
  logic [MAG_W-1:0]   mul_a;
  logic [MAG_W-1:0]   mul_b;
  logic [2*MAG_W-1:0] prod;
  logic signed [SIN_W-1:0] mag_s;

  always_comb begin
    state_next = state;
    case (state)
      SIN_IDLE: if (start) state_next = SIN_Z2;
      SIN_Z2:   state_next = SIN_T1;
      SIN_T1:   state_next = SIN_T2;
      SIN_T2:   state_next = SIN_T3;
      SIN_T3:   state_next = SIN_DONE;
      SIN_DONE: state_next = SIN_IDLE;
      default:  state_next = SIN_IDLE;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    done  = 1'b0;
    case (state)
      SIN_Z2: begin
        mul_a = z;
        mul_b = z;
      end
      SIN_T1: begin
        mul_a = SIN_C1;
        mul_b = acc;
      end
      SIN_T2: begin
        mul_a = z2;
        mul_b = SIN_C2 - acc;
      end
      SIN_T3: begin
        mul_a = z;
        mul_b = SIN_C3 - acc;
      end
      SIN_DONE: done = 1'b1;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{MAG_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SIN_IDLE: begin
        if (start) begin
          neg <= phase[PHASE_W-1];
          // fold odd quadrants onto the rising quarter wave
          if (phase[PHASE_W-2]) begin
            z <= MAG_W'(PHASE_QUARTER - {2'b00, phase[PHASE_W-3:0]});
          end else begin
            z <= {1'b0, phase[PHASE_W-3:0]};
          end
        end
      end
      SIN_Z2, SIN_T2, SIN_T3: acc <= prod[FRAC_SHIFT +: MAG_W];
      SIN_T1: begin
        z2  <= acc;
        acc <= prod[FRAC_SHIFT +: MAG_W];
      end
      default: acc <= acc;
    endcase
  end

  assign mag_s = $signed({1'b0, acc});
  assign value = neg ? -mag_s : mag_s;

endmodule

/* src/rcrs_div.sv */
// Restoring divider for the range fraction, one quotient bit per cycle.
// Depends on rcrs_pkg.
module rcrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rcrs_pkg::STEPS_W-1:0]  steps,
  input  logic [rcrs_pkg::RANGE_W-1:0]  divisor,
  output logic                          done,
  output logic [rcrs_pkg::FRAC_W-1:0]   quotient
);
  import rcrs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy;
  logic               done_r;
  logic [CNT_W-1:0]   count;
  logic [DIV_W-1:0]   num;
  logic [RANGE_W-1:0] rem;
  logic [RANGE_W-1:0] dvs;
  logic [FRAC_W-1:0]  quot;
  logic [RANGE_W:0]   trial;
  logic               ge;

  assign trial = {rem, num[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      count  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // round to nearest: add half the divisor before dividing
      num  <= DIV_W'({steps, 16'h0000}) + DIV_W'(divisor[RANGE_W-1:1]);
      rem  <= '0;
      quot <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= ge ? RANGE_W'(trial - {1'b0, dvs}) : RANGE_W'(trial);
      quot <= {quot[FRAC_W-2:0], ge};
    end
  end

  assign done     = done_r;
  // zero range gives a zero fraction
  assign quotient = (dvs == '0) ? '0 : quot;

endmodule

/* bench/tb_ray_cast_range_sensor_unit.sv */
// Self-checking bench for ray_cast_range_sensor_unit: map writes, five-beam scans, max_range.
// Predicts every beam result from its own occupancy map and checks the result items in order.
// Depends on rcrs_pkg and the unit's RTL only.
module tb_ray_cast_range_sensor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rcrs_pkg::*;

  localparam int MAP_W         = 512;
  localparam int MAP_H         = 512;
  localparam int MAP_CELLS     = MAP_W * MAP_H;
  localparam int SETTLE_CYCLES = 10;     // a write item is done in its own cycle
  localparam int DRAIN_CYCLES  = 300;    // longer than one beam at the ranges used last
  localparam int REPORT_LINES  = 50;

  // One expected beam result
  typedef struct {
    beam_t                beam;
    logic [8:0]           hit_x;
    logic [8:0]           hit_y;
    logic [STEPS_W-1:0]   steps;
    logic [FRAC_W-1:0]    frac;
    logic                 collided;
    logic                 last;
  } beam_hit_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [RANGE_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;

  // Bench copy of the block state
  bit                    wall_map   [MAP_CELLS];
  bit                    cell_known [MAP_CELLS];   // cells written so far
  logic [RANGE_W-1:0]    range_model = RANGE_RESET;
  int                    dir_x [5];                // beam directions, Q1.14
  int                    dir_y [5];

  beam_hit_t             pending_hits [$];
  int                    fault_count = 0;
  bit                    gaps_on     = 1'b1;       // sender idles in bursts
  bit                    stalls_on   = 1'b1;       // receiver stalls in bursts

  ray_cast_range_sensor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("ray_cast_range_sensor_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Q1.14 sine of a 16-bit phase: quadrant fold, then the odd polynomial
  function automatic int sine_q14(logic [PHASE_W-1:0] ph);
    int unsigned z;
    int unsigned z2;
    int unsigned t;
    z = ph[13:0];
    if (ph[14]) begin
      z = PHASE_QUARTER - z;
    end
    z2 = (z * z) >> 14;
    t  = (SIN_C1 * z2) >> 14;
    t  = (z2 * (SIN_C2 - t)) >> 14;
    t  = (z * (SIN_C3 - t)) >> 14;
    return ph[15] ? -int'(t) : int'(t);
  endfunction

  function automatic int cosine_q14(logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] shifted;
    shifted = ph + PHASE_QUARTER;
    return sine_q14(shifted);
  endfunction

  // Load the five beam directions for a heading
  function automatic void aim_beams(logic [HEAD_W-1:0] heading);
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] ph_left;
    logic [PHASE_W-1:0] ph_right;
    ph       = {heading, 4'b0000};
    ph_left  = ph + PHASE_EIGHTH;
    ph_right = ph - PHASE_EIGHTH;
    dir_x[BEAM_FRONT]   = cosine_q14(ph);
    dir_y[BEAM_FRONT]   = sine_q14(ph);
    dir_x[BEAM_LEFT]    = sine_q14(ph);
    dir_y[BEAM_LEFT]    = -cosine_q14(ph);
    dir_x[BEAM_RIGHT]   = -sine_q14(ph);
    dir_y[BEAM_RIGHT]   = cosine_q14(ph);
    dir_x[BEAM_LEFT45]  = sine_q14(ph_left);
    dir_y[BEAM_LEFT45]  = -cosine_q14(ph_left);
    dir_x[BEAM_RIGHT45] = -sine_q14(ph_right);
    dir_y[BEAM_RIGHT45] = cosine_q14(ph_right);
  endfunction

  // Beam coordinate in Q.14 after k unit steps
  function automatic longint beam_coord(logic [16:0] pos, int dir, int unsigned k);
    return longint'(pos) * 64 + longint'(k) * dir;
  endfunction

  // Negative coordinates map to cell -1, which is off the map
  function automatic longint to_cell(longint q14);
    return (q14 < 0) ? -1 : (q14 >>> 14);
  endfunction

  function automatic bit in_map(longint cx, longint cy);
    return cx >= 0 && cy >= 0 && cx < MAP_W && cy < MAP_H;
  endfunction

  // Off-map cells count as walls
  function automatic bit is_wall(longint cx, longint cy);
    if (!in_map(cx, cy)) begin
      return 1'b1;
    end
    return wall_map[cy * MAP_W + cx];
  endfunction

  function automatic logic [8:0] clamp_cell(longint c, int limit);
    if (c < 0) begin
      c = 0;
    end
    if (c >= limit) begin
      c = limit - 1;
    end
    return c[8:0];
  endfunction

  // Walk all five beams over the bench map and queue the expected results
  function automatic void predict_beam_hits(logic [16:0] px, logic [16:0] py,
                                            logic [HEAD_W-1:0] heading);
    beam_hit_t   want;
    bit          self_hit;
    int unsigned k;
    longint      cx;
    longint      cy;
    longint      frac;
    aim_beams(heading);
    self_hit = is_wall(to_cell(longint'(px) * 64), to_cell(longint'(py) * 64));
    for (int b = BEAM_FRONT; b <= BEAM_RIGHT45; b++) begin
      k  = 0;
      cx = to_cell(beam_coord(px, dir_x[b], k));
      cy = to_cell(beam_coord(py, dir_y[b], k));
      // advance until a wall or the range limit
      while (!is_wall(cx, cy) && k < range_model) begin
        k++;
        cx = to_cell(beam_coord(px, dir_x[b], k));
        cy = to_cell(beam_coord(py, dir_y[b], k));
      end
      frac = 0;
      if (range_model != 0) begin
        frac = ((longint'(k) << 16) + range_model / 2) / range_model;
      end
      want.beam     = beam_t'(b);
      want.hit_x    = clamp_cell(cx, MAP_W);
      want.hit_y    = clamp_cell(cy, MAP_H);
      want.steps    = k[STEPS_W-1:0];
      want.frac     = frac[FRAC_W-1:0];
      want.collided = self_hit;
      want.last     = (b == BEAM_RIGHT45);
      pending_hits.push_back(want);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_error(string what, longint got, longint want);
    fault_count++;
    if (fault_count <= REPORT_LINES) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : check_hits
    beam_hit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        report_error("result item with none pending, beam", m_tuser, 0);
      end else begin
        want = pending_hits.pop_front();
        if (m_tuser != want.beam)
          report_error("beam index", m_tuser, want.beam);
        if (m_tdata[8:0] != want.hit_x)
          report_error("hit_x", m_tdata[8:0], want.hit_x);
        if (m_tdata[17:9] != want.hit_y)
          report_error("hit_y", m_tdata[17:9], want.hit_y);
        if (m_tdata[27:18] != want.steps)
          report_error("steps", m_tdata[27:18], want.steps);
        if (m_tdata[44:28] != want.frac)
          report_error("range_fraction", m_tdata[44:28], want.frac);
        if (m_tdata[45] != want.collided)
          report_error("collided", m_tdata[45], want.collided);
        if (m_tlast != want.last)
          report_error("last", m_tlast, want.last);
      end
    end
  end

  // Receiver: stall in random bursts while stalls are on
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Drive one item and hold it until accepted; tvalid stays high afterwards
  // so the next item follows back to back unless a gap is drawn.
  task automatic send_item(logic kind, logic [8:0] cx, logic [8:0] cy, logic occ,
                           logic [16:0] px, logic [16:0] py, logic [HEAD_W-1:0] heading);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'b0, heading, py, px, occ, cy, cx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_WRITE) begin
      wall_map[int'(cy) * MAP_W + cx]   = occ;
      cell_known[int'(cy) * MAP_W + cx] = 1'b1;
    end else begin
      predict_beam_hits(px, py, heading);
    end
  endtask

  // Unused fields of an item carry random bits
  task automatic write_cell(logic [8:0] cx, logic [8:0] cy, logic occ);
    send_item(KIND_WRITE, cx, cy, occ, 17'($urandom), 17'($urandom), 12'($urandom));
  endtask

  task automatic scan(logic [16:0] px, logic [16:0] py, logic [HEAD_W-1:0] heading);
    send_item(KIND_SCAN, 9'($urandom), 9'($urandom), 1'($urandom), px, py, heading);
  endtask

  // Write a cell not yet written, as a wall with the given odds in percent
  task automatic settle_cell(longint cx, longint cy, int odds);
    if (in_map(cx, cy) && !cell_known[cy * MAP_W + cx]) begin
      write_cell(cx[8:0], cy[8:0], $urandom_range(0, 99) < odds);
    end
  endtask

  // Write every map cell the scan could read, then send the scan. The whole
  // path to one step past the range is covered, walls or not, so the unit
  // never reads a cell that was never written.
  task automatic prepare_and_scan(logic [16:0] px, logic [16:0] py,
                                  logic [HEAD_W-1:0] heading, int odds);
    aim_beams(heading);
    settle_cell(to_cell(longint'(px) * 64), to_cell(longint'(py) * 64), odds);
    for (int b = BEAM_FRONT; b <= BEAM_RIGHT45; b++) begin
      for (int unsigned k = 0; k <= range_model + 1; k++) begin
        settle_cell(to_cell(beam_coord(px, dir_x[b], k)),
                    to_cell(beam_coord(py, dir_y[b], k)), odds);
      end
    end
    scan(px, py, heading);
  endtask

  // Write max_range only with the unit idle: drain all results first
  task automatic set_range(logic [RANGE_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    range_model  = value;
  endtask

  // Positions anywhere, near both map edges or in one busy patch at cells 100 to 139
  function automatic logic [16:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 17'($urandom);
      1:       return 17'($urandom_range(0, 2047));
      2:       return 17'($urandom_range(129024, 131071));
      default: return 17'($urandom_range(25600, 35839));
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 15;
      default: return 50;
    endcase
  endfunction

  // Mostly scans over fresh or reused ground, some stray map writes
  task automatic random_items(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        write_cell(9'($urandom), 9'($urandom), 1'($urandom));
      end else begin
        prepare_and_scan(pick_coord(), pick_coord(), 12'($urandom), pick_odds());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner cells with both values; later corner scans read them
  task automatic test_write_extremes();
    write_cell(9'd0, 9'd0, 1'b1);
    write_cell(9'd511, 9'd511, 1'b0);
    write_cell(9'd511, 9'd0, 1'b1);
    write_cell(9'd0, 9'd511, 1'b0);
  endtask

  // Open ground at the reset range: every beam runs the full range
  task automatic test_open_field();
    logic [16:0] center;
    center = 17'd65664;
    prepare_and_scan(center, center, 12'd0, 0);
    prepare_and_scan(center, center, 12'd512, 0);   // 45 degrees
    prepare_and_scan(center, center, 12'd1024, 0);
    prepare_and_scan(center, center, 12'd2048, 0);
    prepare_and_scan(center, center, 12'd3072, 0);
    prepare_and_scan(center, center, 12'd4095, 0);
  endtask

  // Sensor standing in a wall: all beams stop at step 0
  task automatic test_self_collision();
    write_cell(9'd300, 9'd300, 1'b1);
    prepare_and_scan(17'(300 * 256 + 7), 17'(300 * 256 + 250), 12'($urandom), 10);
    prepare_and_scan(17'd0, 17'd0, 12'd1024, 0);     // corner cell written as wall
  endtask

  // Beams leaving the map stop there and report clamped cells
  task automatic test_map_borders();
    prepare_and_scan(17'd131071, 17'd131071, 12'd0, 0);
    prepare_and_scan(17'd131071, 17'd300, 12'd3072, 0);
    prepare_and_scan(17'd200, 17'd131071, 12'd2048, 0);
    prepare_and_scan(17'd5, 17'd65000, 12'd2048, 0);
    prepare_and_scan(17'd131071, 17'd70000, 12'd1024, 0);
  endtask

  // Shortest, zero and longest range
  task automatic test_range_extremes();
    set_range(10'd1);
    prepare_and_scan(17'd65664, 17'd65664, 12'($urandom), 20);
    set_range(10'd0);
    prepare_and_scan(17'd40000, 17'd90000, 12'($urandom), 20);
    set_range(10'd1023);
    prepare_and_scan(17'(256 + 128), 17'(256 + 128), 12'd512, 0);  // diagonal across the map
  endtask

  // Random phases at several ranges, with idling switched per phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_range(10'($urandom_range(1, 16)));
        1:       set_range(10'($urandom_range(17, 64)));
        2:       set_range(10'($urandom_range(65, 200)));
        default: set_range(10'($urandom_range(1, 40)));
      endcase
      gaps_on   = (phase != 1);
      stalls_on = (phase != 2);
      random_items(20);
    end
  endtask

  // Last stretch: no gaps and no stalls
  task automatic test_steady_stream();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_range(10'($urandom_range(1, 50)));
    random_items(20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_write_extremes();
    test_open_field();
    test_self_collision();
    test_map_borders();
    test_range_extremes();
    test_random_traffic();
    test_steady_stream();

    // drain, then watch for stray results
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("ray_cast_range_sensor_unit: match");
    end else begin
      $display("ray_cast_range_sensor_unit: mismatch");
    end
    $finish;
  end

endmodule
